### design/aric_pkg.sv
// ----------------------------------------------------------------------------
// aric_pkg: shared types and constants of the refresh interval controller
// Request and result payloads, configuration set, per-channel state record
// and register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package aric_pkg;

  // configuration port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes (byte address is four times the index)
  localparam logic [2:0] REG_BASE_INTERVAL = 3'd0;
  localparam logic [2:0] REG_LIMIT_OFFSET  = 3'd1;
  localparam logic [2:0] REG_LIMIT_SLOPE   = 3'd2;
  localparam logic [2:0] REG_GROW_STEP     = 3'd3;
  localparam logic [2:0] REG_SHRINK_STEP   = 3'd4;

  // register reset values
  localparam logic [14:0] BASE_INTERVAL_RST = 15'd7280;
  localparam logic [15:0] LIMIT_OFFSET_RST  = 16'd32767;
  localparam logic [9:0]  LIMIT_SLOPE_RST   = 10'd100;
  localparam logic [11:0] GROW_STEP_RST     = 12'd16;
  localparam logic [11:0] SHRINK_STEP_RST   = 12'd16;

  // temperature clamp, ceiling margin and interval limit
  localparam int TEMP_MIN    = 5;
  localparam int TEMP_MAX    = 85;
  localparam int CEIL_MARGIN = 16;
  localparam logic [14:0] MAX15 = 15'h7fff;

  typedef struct packed {
    logic [1:0]  chan_index;
    logic [7:0]  temperature;
    logic [31:0] error_word;
    logic [14:0] current_interval;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [14:0] new_interval;
    logic        errors_now;
    logic        rank1_flag;
    logic        rank0_flag;
  } out_item_t;

  typedef struct packed {
    logic [14:0] base_interval;
    logic [15:0] limit_offset;
    logic [9:0]  limit_slope;
    logic [11:0] grow_step;
    logic [11:0] shrink_step;
  } cfg_t;

  typedef struct packed {
    logic [14:0] prev_rank1_count;
    logic [14:0] prev_rank0_count;
    logic        rank1_detect;
    logic        rank0_detect;
  } chan_state_t;

endpackage

`default_nettype wire

### design/aric_regs.sv
// ----------------------------------------------------------------------------
// aric_regs: configuration register file
// APB-style write and read access to the five controller settings.
// ----------------------------------------------------------------------------
`default_nettype none

module aric_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [aric_pkg::ADDR_W-1:0] paddr,
  input  wire logic [aric_pkg::DATA_W-1:0] pwdata,
  output logic      [aric_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output aric_pkg::cfg_t                 cfg
);
  import aric_pkg::*;

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_interval <= BASE_INTERVAL_RST;
      cfg.limit_offset  <= LIMIT_OFFSET_RST;
      cfg.limit_slope   <= LIMIT_SLOPE_RST;
      cfg.grow_step     <= GROW_STEP_RST;
      cfg.shrink_step   <= SHRINK_STEP_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BASE_INTERVAL: cfg.base_interval <= pwdata[14:0];
        REG_LIMIT_OFFSET:  cfg.limit_offset  <= pwdata[15:0];
        REG_LIMIT_SLOPE:   cfg.limit_slope   <= pwdata[9:0];
        REG_GROW_STEP:     cfg.grow_step     <= pwdata[11:0];
        REG_SHRINK_STEP:   cfg.shrink_step   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_BASE_INTERVAL: prdata = DATA_W'(cfg.base_interval);
      REG_LIMIT_OFFSET:  prdata = DATA_W'(cfg.limit_offset);
      REG_LIMIT_SLOPE:   prdata = DATA_W'(cfg.limit_slope);
      REG_GROW_STEP:     prdata = DATA_W'(cfg.grow_step);
      REG_SHRINK_STEP:   prdata = DATA_W'(cfg.shrink_step);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/aric_update.sv
// ----------------------------------------------------------------------------
// aric_update: interval update for one sample
// Temperature ceiling, error detection, grow or shrink decision, floor and
// saturation, and the next state of the sampled channel.
// ----------------------------------------------------------------------------
`default_nettype none

module aric_update (
  input  wire aric_pkg::in_item_t    item,
  input  wire aric_pkg::cfg_t        cfg,
  input  wire aric_pkg::chan_state_t state,
  output aric_pkg::chan_state_t      state_next,
  output logic [14:0]                new_interval,
  output logic                       errors_now
);
  import aric_pkg::*;

  logic [6:0]         temp_c;
  logic [16:0]        product;
  logic signed [17:0] ceil_diff;
  logic [14:0]        ceil_val;
  logic signed [16:0] shrink_diff;
  logic [14:0]        shrunk;
  logic [15:0]        grown;
  logic               below_ceil;
  logic               ov1, ov0, up1, up0;
  logic [14:0]        cnt1, cnt0;
  logic [15:0]        nv;
  logic [13:0]        floor_val;
  logic [15:0]        floored;

  // clamp temperature to the valid sensor range
  always_comb begin
    if (item.temperature < 8'(TEMP_MIN)) begin
      temp_c = 7'(TEMP_MIN);
    end else if (item.temperature > 8'(TEMP_MAX)) begin
      temp_c = 7'(TEMP_MAX);
    end else begin
      temp_c = item.temperature[6:0];
    end
  end

  // temperature-dependent ceiling, saturated to 15 bits
  assign product   = 17'(cfg.limit_slope) * 17'(temp_c);
  assign ceil_diff = $signed({2'b00, cfg.limit_offset}) - $signed({1'b0, product});

  always_comb begin
    if (ceil_diff < 0) begin
      ceil_val = '0;
    end else if (ceil_diff > $signed({3'b000, MAX15})) begin
      ceil_val = MAX15;
    end else begin
      ceil_val = ceil_diff[14:0];
    end
  end

  // error word unpack and detection against the last counts
  assign ov1  = item.error_word[31];
  assign cnt1 = item.error_word[30:16];
  assign ov0  = item.error_word[15];
  assign cnt0 = item.error_word[14:0];
  assign up1  = ov1 || (state.prev_rank1_count < cnt1);
  assign up0  = ov0 || (state.prev_rank0_count < cnt0);
  assign errors_now = up1 || up0;

  // candidate intervals
  assign shrink_diff = $signed({2'b00, item.current_interval})
                     - $signed({4'b0000, cfg.shrink_step, 1'b0});
  assign shrunk      = shrink_diff[16] ? '0 : shrink_diff[14:0];
  assign grown       = {1'b0, item.current_interval} + 16'(cfg.grow_step);
  assign below_ceil  = ({1'b0, item.current_interval} + 16'(CEIL_MARGIN))
                     < {1'b0, ceil_val};

  // decision and flag update
  always_comb begin
    state_next.prev_rank1_count = cnt1;
    state_next.prev_rank0_count = cnt0;
    state_next.rank1_detect     = state.rank1_detect;
    state_next.rank0_detect     = state.rank0_detect;
    if (errors_now) begin
      state_next.rank1_detect = state.rank1_detect || up1;
      state_next.rank0_detect = state.rank0_detect || up0;
      nv = {1'b0, shrunk};
    end else if (!state.rank1_detect && !state.rank0_detect) begin
      nv = below_ceil ? grown : {1'b0, ceil_val};
    end else if (state.rank1_detect) begin
      // recovery clears rank 1 first
      state_next.rank1_detect = 1'b0;
      nv = {1'b0, shrunk};
    end else begin
      state_next.rank0_detect = 1'b0;
      nv = {1'b0, shrunk};
    end
  end

  // floor at half the base interval, then saturate
  assign floor_val    = cfg.base_interval[14:1];
  assign floored      = (nv < {2'b00, floor_val}) ? {2'b00, floor_val} : nv;
  assign new_interval = (floored > {1'b0, MAX15}) ? MAX15 : floored[14:0];

endmodule

`default_nettype wire

### design/adaptive_refresh_interval_controller.sv
// ----------------------------------------------------------------------------
// adaptive_refresh_interval_controller: per-channel refresh interval update
// Samples a channel's temperature and error counters and returns the
// refresh interval to program for that channel.
// ----------------------------------------------------------------------------
// Usage
//   sample channel: a request carries channel, temperature, error word and the
//   interval now programmed; it is taken when sample_valid is high and
//   sample_stall low. result channel: one result per request, in order, held
//   while result_stall is high.
//   Data path: a taken request waits in the input register and moves into the
//   result register, where it is presented, once that register is free.
//   Throughput: one request per cycle while result_stall is low; the
//   per-channel counts and flags are written when a request moves
//   into the result register, so the request behind it sees them at once.
//   When the receiver stalls, the result register holds and the input
//   register takes one more request before sample_stall rises.
//   Settings are written through the APB-style port while no request is in
//   flight. Reset clears both registers, the per-channel state and restores
//   the settings' reset values; there is no clearing pass.
//   A channel index not below NUM_CHANNELS is treated as channel 0.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_refresh_interval_controller #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        sample_valid,
  output logic                             sample_stall,
  input  wire aric_pkg::in_item_t          sample,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output aric_pkg::out_item_t              result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [aric_pkg::ADDR_W-1:0] paddr,
  input  wire logic [aric_pkg::DATA_W-1:0] pwdata,
  output logic      [aric_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import aric_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  cfg_t        cfg;
  in_item_t    item;
  logic        item_valid;
  logic        res_free;
  logic        advance;
  logic [4:0]  ch_ext;
  logic        ch_in_range;
  logic [CH_W-1:0] ch_idx;
  chan_state_t chan_st [NUM_CHANNELS];
  chan_state_t st_cur;
  chan_state_t st_next;
  logic [14:0] new_interval;
  logic        errors_now;

  // configuration registers
  aric_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: input register empties into the result register
  assign res_free     = !result_valid || !result_stall;
  assign advance      = item_valid && res_free;
  assign sample_stall = item_valid && !res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!sample_stall) begin
      item_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      item <= sample;
    end
  end

  // channel select, out-of-range indexes fold onto channel 0
  assign ch_ext      = 5'(item.chan_index);
  assign ch_in_range = ch_ext < 5'(NUM_CHANNELS);
  assign ch_idx      = ch_in_range ? ch_ext[CH_W-1:0] : '0;
  assign st_cur      = chan_st[ch_idx];

  aric_update u_update (
    .item         (item),
    .cfg          (cfg),
    .state        (st_cur),
    .state_next   (st_next),
    .new_interval (new_interval),
    .errors_now   (errors_now)
  );

  // per-channel counts and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_st[i] <= '0;
      end
    end else if (advance) begin
      chan_st[ch_idx] <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_free) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.out_channel  <= ch_in_range ? item.chan_index : 2'd0;
      result.new_interval <= new_interval;
      result.errors_now   <= errors_now;
      result.rank1_flag   <= st_next.rank1_detect;
      result.rank0_flag   <= st_next.rank0_detect;
    end
  end

  // checks
  a_err_sets_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.errors_now |-> result.rank1_flag || result.rank0_flag)
    else $error("error result without a detect flag");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> item_valid && result_valid && result_stall)
    else $error("input stalled without a blocked request");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("request moved on but no result presented");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_valid)
    else $error("registers not empty after reset");

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the adaptive refresh interval controller
// Sends channel samples through the valid/stall request port and checks every
// interval update against an in-bench model of the per-channel counts, detect
// flags and interval rules. A short table of directed samples comes first.
// Several register settings follow, extremes included, each with a burst of
// random samples. Both sides idle at random, and one long receiver hold-off
// fills the block.
// ----------------------------------------------------------------------------

module tb_top;
  import aric_pkg::*;

  localparam int CHANNELS        = 4;
  localparam int ITEMS_PER_PHASE = 247;
  localparam int NUM_PHASES      = 7;
  localparam int HOLD_CYCLES     = 64;

  // directed table row: pinned rows carry a hand-worked update
  typedef struct packed {
    logic      pinned;
    in_item_t  stim;
    out_item_t want;
  } sample_row_t;

  localparam sample_row_t DIRECTED [21] = '{
    '{1'b1, '{2'd0, 8'd0,   32'h0000_0000, 15'd0},     '{2'd0, 15'd3640,  1'b0, 1'b0, 1'b0}},
    '{1'b1, '{2'd1, 8'd255, 32'h0000_0000, 15'd32767}, '{2'd1, 15'd24267, 1'b0, 1'b0, 1'b0}},
    '{1'b1, '{2'd2, 8'd0,   32'h8000_0000, 15'd32767}, '{2'd2, 15'd32735, 1'b1, 1'b1, 1'b0}},
    '{1'b1, '{2'd2, 8'd0,   32'h0000_0000, 15'd100},   '{2'd2, 15'd3640,  1'b0, 1'b0, 1'b0}},
    '{1'b1, '{2'd3, 8'd40,  32'h0000_ffff, 15'd5000},  '{2'd3, 15'd4968,  1'b1, 1'b0, 1'b1}},
    '{1'b1, '{2'd3, 8'd40,  32'h7fff_7fff, 15'd0},     '{2'd3, 15'd3640,  1'b1, 1'b1, 1'b1}},
    '{1'b1, '{2'd3, 8'd40,  32'h7fff_7fff, 15'd20000}, '{2'd3, 15'd19968, 1'b0, 1'b0, 1'b1}},
    '{1'b1, '{2'd3, 8'd40,  32'h7fff_7fff, 15'd20000}, '{2'd3, 15'd19968, 1'b0, 1'b0, 1'b0}},
    '{1'b1, '{2'd3, 8'd50,  32'h7fff_7fff, 15'd20000}, '{2'd3, 15'd20016, 1'b0, 1'b0, 1'b0}},
    '{1'b0, '{2'd3, 8'd50,  32'h0000_0000, 15'd27751}, '0},
    '{1'b0, '{2'd3, 8'd50,  32'h0000_0000, 15'd27750}, '0},
    '{1'b0, '{2'd0, 8'd4,   32'h0000_0000, 15'd30000}, '0},
    '{1'b0, '{2'd0, 8'd5,   32'h0000_0000, 15'd32260}, '0},
    '{1'b0, '{2'd0, 8'd85,  32'h0000_0000, 15'd24252}, '0},
    '{1'b0, '{2'd0, 8'd86,  32'h0000_0000, 15'd24252}, '0},
    '{1'b0, '{2'd1, 8'd200, 32'h0001_0001, 15'd32767}, '0},
    '{1'b0, '{2'd1, 8'd200, 32'h0001_0001, 15'd10},    '0},
    '{1'b0, '{2'd1, 8'd200, 32'h0001_0001, 15'd10},    '0},
    '{1'b1, '{2'd0, 8'd0,   32'hffff_ffff, 15'd32767}, '{2'd0, 15'd32735, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '{2'd0, 8'd0,   32'h7fff_7fff, 15'd31},    '0},
    '{1'b0, '{2'd2, 8'd255, 32'h5555_2aaa, 15'd12345}, '0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  wire               sample_stall;
  in_item_t          sample = '0;
  wire               result_valid;
  logic              result_stall = 1'b0;
  out_item_t         result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  wire  [DATA_W-1:0] prdata;
  wire               pready;

  // travels with each request: hand-worked update for pinned table rows
  logic              pinned = 1'b0;
  out_item_t         pinned_result = '0;

  // model state and settings
  cfg_t              cfg_shadow;
  chan_state_t       chan_state [CHANNELS];
  out_item_t         pending_updates [$];
  out_item_t         forecast;
  out_item_t         want_item;
  int                bad_updates = 0;

  // stimulus controls
  logic              idling_on = 1'b1;
  logic              hold_request = 1'b0;
  logic [14:0]       last_rank1 [CHANNELS] = '{default: '0};
  logic [14:0]       last_rank0 [CHANNELS] = '{default: '0};

  adaptive_refresh_interval_controller #(
    .NUM_CHANNELS(CHANNELS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // saturate to the 15-bit interval range
  function automatic logic [14:0] to_interval(input int v);
    if (v < 0) return '0;
    if (v > int'(MAX15)) return MAX15;
    return 15'(v);
  endfunction

  // temperature-dependent interval ceiling under the current settings
  function automatic int ceiling_for(input logic [7:0] temp);
    int t;
    t = int'(temp);
    if (t < TEMP_MIN) t = TEMP_MIN;
    if (t > TEMP_MAX) t = TEMP_MAX;
    return int'(to_interval(int'(cfg_shadow.limit_offset) - int'(cfg_shadow.limit_slope) * t));
  endfunction

  // next interval, flags and error indication for one sample
  function automatic out_item_t predict_refresh(input in_item_t s);
    int        ch;
    int        ceil_v;
    int        cur;
    int        shrunk;
    int        nv;
    int        floor_v;
    logic      up1;
    logic      up0;
    logic      errs;
    out_item_t r;
    ch = int'(s.chan_index);
    if (ch >= CHANNELS) ch = 0;
    ceil_v = ceiling_for(s.temperature);
    up1 = s.error_word[31] || (chan_state[ch].prev_rank1_count < s.error_word[30:16]);
    up0 = s.error_word[15] || (chan_state[ch].prev_rank0_count < s.error_word[14:0]);
    errs = up1 || up0;
    cur = int'(s.current_interval);
    shrunk = cur - 2 * int'(cfg_shadow.shrink_step);
    if (shrunk < 0) shrunk = 0;
    if (errs) begin
      if (up1) chan_state[ch].rank1_detect = 1'b1;
      if (up0) chan_state[ch].rank0_detect = 1'b1;
      nv = shrunk;
    end else if (chan_state[ch].rank1_detect) begin
      // recovery clears rank 1 ahead of rank 0
      chan_state[ch].rank1_detect = 1'b0;
      nv = shrunk;
    end else if (chan_state[ch].rank0_detect) begin
      chan_state[ch].rank0_detect = 1'b0;
      nv = shrunk;
    end else if (cur < ceil_v - CEIL_MARGIN) begin
      nv = cur + int'(cfg_shadow.grow_step);
    end else begin
      nv = ceil_v;
    end
    floor_v = int'(cfg_shadow.base_interval >> 1);
    if (nv < floor_v) nv = floor_v;
    chan_state[ch].prev_rank1_count = s.error_word[30:16];
    chan_state[ch].prev_rank0_count = s.error_word[14:0];
    r.out_channel  = 2'(ch);
    r.new_interval = to_interval(nv);
    r.errors_now   = errs;
    r.rank1_flag   = chan_state[ch].rank1_detect;
    r.rank0_flag   = chan_state[ch].rank0_detect;
    return r;
  endfunction

  // error count for a rank: mostly unchanged, sometimes rising, rarely odd
  function automatic logic [14:0] next_count(input logic [14:0] last);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return last;
      5, 6:          return last + 15'($urandom_range(1, 3));
      7:             return 15'($urandom);
      8:             return '0;
      default:       return last - 15'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t    s;
    int          ch;
    logic [14:0] cnt1;
    logic [14:0] cnt0;
    ch = $urandom_range(0, CHANNELS - 1);
    s.chan_index = 2'(ch);
    s.temperature = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
    cnt1 = next_count(last_rank1[ch]);
    cnt0 = next_count(last_rank0[ch]);
    last_rank1[ch] = cnt1;
    last_rank0[ch] = cnt0;
    s.error_word = {($urandom_range(0, 9) == 0), cnt1, ($urandom_range(0, 9) == 0), cnt0};
    // interval near the ceiling, near the floor, small or anywhere
    case ($urandom_range(0, 9))
      0, 1, 2: s.current_interval = 15'($urandom);
      3, 4, 5: s.current_interval =
                 to_interval(ceiling_for(s.temperature) + $urandom_range(0, 40) - 24);
      6, 7:    s.current_interval =
                 to_interval(int'(cfg_shadow.base_interval >> 1) + $urandom_range(0, 40) - 20);
      default: s.current_interval = 15'($urandom_range(0, 100));
    endcase
    return s;
  endfunction

  // register write: setup cycle, then access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BASE_INTERVAL: cfg_shadow.base_interval = val[14:0];
      REG_LIMIT_OFFSET:  cfg_shadow.limit_offset  = val[15:0];
      REG_LIMIT_SLOPE:   cfg_shadow.limit_slope   = val[9:0];
      REG_GROW_STEP:     cfg_shadow.grow_step     = val[11:0];
      REG_SHRINK_STEP:   cfg_shadow.shrink_step   = val[11:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input cfg_t c);
    reg_write(REG_BASE_INTERVAL, 32'(c.base_interval));
    reg_write(REG_LIMIT_OFFSET,  32'(c.limit_offset));
    reg_write(REG_LIMIT_SLOPE,   32'(c.limit_slope));
    reg_write(REG_GROW_STEP,     32'(c.grow_step));
    reg_write(REG_SHRINK_STEP,   32'(c.shrink_step));
  endtask

  // offer one request, with an optional gap first, and wait until taken
  task automatic send_sample(input in_item_t s, input logic pin, input out_item_t want);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    sample_valid  <= 1'b1;
    sample        <= s;
    pinned        <= pin;
    pinned_result <= want;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // stop offering and let every outstanding update come back
  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // model runs on every request taken
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      forecast = predict_refresh(sample);
      pending_updates.push_back(pinned ? pinned_result : forecast);
    end
  end

  // compare each update taken with the oldest expected one
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_updates.size() == 0) begin
        if (bad_updates < 10)
          $display("unexpected update: ch=%0d interval=%0d", result.out_channel,
                   result.new_interval);
        bad_updates++;
      end else begin
        want_item = pending_updates.pop_front();
        if (result.out_channel !== want_item.out_channel ||
            result.new_interval !== want_item.new_interval ||
            result.errors_now !== want_item.errors_now ||
            result.rank1_flag !== want_item.rank1_flag ||
            result.rank0_flag !== want_item.rank0_flag) begin
          if (bad_updates < 10)
            $display("update mismatch: exp ch=%0d int=%0d err=%0d r1=%0d r0=%0d, got ch=%0d int=%0d err=%0d r1=%0d r0=%0d",
                     want_item.out_channel, want_item.new_interval, want_item.errors_now,
                     want_item.rank1_flag, want_item.rank0_flag, result.out_channel,
                     result.new_interval, result.errors_now, result.rank1_flag,
                     result.rank0_flag);
          bad_updates++;
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (idling_on && !rst && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // main sequence
  initial begin
    cfg_t phase_cfg;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    cfg_shadow = '{BASE_INTERVAL_RST, LIMIT_OFFSET_RST, LIMIT_SLOPE_RST, GROW_STEP_RST,
                   SHRINK_STEP_RST};
    foreach (chan_state[i]) chan_state[i] = '0;

    // directed table under reset settings
    foreach (DIRECTED[i]) send_sample(DIRECTED[i].stim, DIRECTED[i].pinned, DIRECTED[i].want);
    wait_idle();

    // random phases: extremes, saturating ceilings, random, then reset values
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_cfg = '0;
        1: phase_cfg = '1;
        2: phase_cfg = '{15'd0, 16'hffff, 10'd0, 12'hfff, 12'd0};
        3: phase_cfg = '{15'd9000, 16'd0, 10'h3ff, 12'd5, 12'd7};
        4: phase_cfg = '{15'($urandom), 16'($urandom), 10'($urandom), 12'($urandom),
                         12'($urandom)};
        5: phase_cfg = '{15'($urandom_range(0, 16000)), 16'($urandom_range(20000, 65535)),
                         10'($urandom_range(0, 300)), 12'($urandom_range(0, 200)),
                         12'($urandom_range(0, 200))};
        default: phase_cfg = '{BASE_INTERVAL_RST, LIMIT_OFFSET_RST, LIMIT_SLOPE_RST,
                               GROW_STEP_RST, SHRINK_STEP_RST};
      endcase
      idling_on = (p != NUM_PHASES - 1);
      if (p == 2) hold_request = 1'b1;
      write_settings(phase_cfg);
      repeat (ITEMS_PER_PHASE) send_sample(random_sample(), 1'b0, '0);
      wait_idle();
    end

    if (bad_updates == 0 && pending_updates.size() == 0) begin
      $display("[adaptive_refresh_interval_controller] OK");
    end else begin
      $display("[adaptive_refresh_interval_controller] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("[adaptive_refresh_interval_controller] ERROR");
    $finish;
  end

endmodule
